[src/ant_message_deframer_defines.svh]
// ----------------------------------------------------------------------------
// ant_message_deframer_defines.svh
// Assertion macros shared by the deframer RTL.
// ----------------------------------------------------------------------------
`ifndef ANT_MESSAGE_DEFRAMER_DEFINES_SVH
`define ANT_MESSAGE_DEFRAMER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define AMDF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define AMDF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[src/amdf_pkg.sv]
// ----------------------------------------------------------------------------
// amdf_pkg
// Types and constants of the serial message deframer.
// ----------------------------------------------------------------------------
package amdf_pkg;

    localparam logic [7:0] SYNC_BYTE = 8'hA4;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_CKSUM    = 2'd1;
    localparam logic [1:0] ST_LEN      = 2'd2;

    typedef enum logic [5:0] {
        PH_HUNT  = 6'b000001,
        PH_LEN   = 6'b000010,
        PH_ID    = 6'b000100,
        PH_DATA  = 6'b001000,
        PH_CKSUM = 6'b010000,
        PH_EMIT  = 6'b100000
    } t_phase;

endpackage

[src/amdf_ram.sv]
// ----------------------------------------------------------------------------
// amdf_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module amdf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/ant_message_deframer.sv]
// ----------------------------------------------------------------------------
// ant_message_deframer - serial message deframer, one rx byte per request.
// Input: one byte per cycle unless in emit or the output is stalled; error and
// empty results are registered, valid in the cycle after the byte. Good frame
// is read entry by entry (single payload RAM read port, registered read).
// Reset (sync, active low) clears control; payload RAM is not cleared.
// ----------------------------------------------------------------------------
//
// Frame: sync 0xA4, length, id, payload bytes, checksum (XOR of sync..payload).
// Bytes before sync are counted (saturating) and reported with the next result.
// Payload bytes go into a small RAM as they arrive; after a good checksum the
// emit phase reads them back one at a time into the output register.
// During emit no rx request is taken. Otherwise an rx request is taken while
// the output register is free or being emptied, so a byte that raises a result
// always finds room.
// ----------------------------------------------------------------------------
`include "ant_message_deframer_defines.svh"

module ant_message_deframer #(
    parameter int MAX_PAYLOAD = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // rx byte channel
    input  logic       i_rx_valid,
    output logic       o_rx_ready,
    input  logic [7:0] i_rx_byte,
    // result channel
    output logic       o_res_valid,
    input  logic       i_res_ready,
    output logic [1:0] o_status,
    output logic [7:0] o_msg_id,
    output logic [7:0] o_msg_len,
    output logic [4:0] o_byte_index,
    output logic [7:0] o_data_byte,
    output logic       o_has_data,
    output logic [7:0] o_skipped_bytes,
    output logic       o_last
);

    localparam int AW  = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int PCW = $clog2(MAX_PAYLOAD + 1);   // holds 0..MAX_PAYLOAD
    localparam logic [7:0]     LP_MAX_LEN = 8'(MAX_PAYLOAD);
    localparam logic [PCW-1:0] LP_MAX_CNT = PCW'(MAX_PAYLOAD);

    // ---- control state ----
    amdf_pkg::t_phase r_phase, n_phase;
    logic [7:0]       r_frame_length, n_frame_length;
    logic [7:0]       r_frame_id, n_frame_id;
    logic [PCW-1:0]   r_payload_count, n_payload_count;
    logic [7:0]       r_xor, n_xor;
    logic [7:0]       r_skip, n_skip;
    logic [PCW-1:0]   r_emit_cnt, n_emit_cnt;   // next entry to read
    logic [PCW-1:0]   r_rd_idx, n_rd_idx;       // entry in flight
    logic             r_rd_pend, n_rd_pend;     // RAM data arrives this cycle

    // ---- output register ----
    logic       r_out_valid, n_out_valid;
    logic [1:0] r_o_status;
    logic [7:0] r_o_id;
    logic [7:0] r_o_len;
    logic [4:0] r_o_idx;
    logic [7:0] r_o_data;
    logic       r_o_has;
    logic [7:0] r_o_skip;
    logic       r_o_last;

    // ---- result load ----
    logic       w_load;
    logic [1:0] w_ld_status;
    logic [7:0] w_ld_id;
    logic [7:0] w_ld_len;
    logic [4:0] w_ld_idx;
    logic [7:0] w_ld_data;
    logic       w_ld_has;
    logic       w_ld_last;
    logic       w_end;

    // ---- RAM ----
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic          w_re;
    logic [7:0]    w_rdata;

    logic w_in_acc;
    logic w_out_free;
    logic w_emit_last;
    logic [PCW-1:0] w_pc_inc;

    amdf_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PAYLOAD)
    ) u_payload_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (i_rx_byte),
        .i_re    (w_re),
        .i_raddr (r_emit_cnt[AW-1:0]),
        .o_rdata (w_rdata)
    );

    assign w_out_free  = !r_out_valid || i_res_ready;
    assign o_rx_ready  = (r_phase != amdf_pkg::PH_EMIT) && w_out_free;
    assign w_in_acc    = i_rx_valid && o_rx_ready;
    assign w_pc_inc    = r_payload_count + 1'b1;
    assign w_waddr     = r_payload_count[AW-1:0];
    assign w_emit_last = ((8'(r_rd_idx) + 8'd1) == r_frame_length);

    always_comb begin
        n_phase         = r_phase;
        n_frame_length  = r_frame_length;
        n_frame_id      = r_frame_id;
        n_payload_count = r_payload_count;
        n_xor           = r_xor;
        n_skip          = r_skip;
        n_emit_cnt      = r_emit_cnt;
        n_rd_idx        = r_rd_idx;
        n_rd_pend       = 1'b0;
        w_we            = 1'b0;
        w_re            = 1'b0;
        w_load          = 1'b0;
        w_ld_status     = amdf_pkg::ST_OK;
        w_ld_id         = r_frame_id;
        w_ld_len        = r_frame_length;
        w_ld_idx        = 5'd0;
        w_ld_data       = 8'd0;
        w_ld_has        = 1'b0;
        w_ld_last       = 1'b1;
        w_end           = 1'b0;

        unique case (r_phase)
            amdf_pkg::PH_HUNT: begin
                if (w_in_acc) begin
                    if (i_rx_byte == amdf_pkg::SYNC_BYTE) begin
                        n_xor           = i_rx_byte;
                        n_payload_count = '0;
                        n_phase         = amdf_pkg::PH_LEN;
                    end else if (r_skip != 8'hFF) begin
                        n_skip = r_skip + 8'd1;
                    end
                end
            end
            amdf_pkg::PH_LEN: begin
                if (w_in_acc) begin
                    n_frame_length = i_rx_byte;
                    n_xor          = r_xor ^ i_rx_byte;
                    if (i_rx_byte > LP_MAX_LEN) begin
                        // id not seen yet: reported as zero
                        w_load      = 1'b1;
                        w_ld_status = amdf_pkg::ST_LEN;
                        w_ld_id     = 8'd0;
                        w_ld_len    = i_rx_byte;
                        w_end       = 1'b1;
                    end else begin
                        n_phase = amdf_pkg::PH_ID;
                    end
                end
            end
            amdf_pkg::PH_ID: begin
                if (w_in_acc) begin
                    n_frame_id      = i_rx_byte;
                    n_xor           = r_xor ^ i_rx_byte;
                    n_payload_count = '0;
                    n_phase         = (r_frame_length == 8'd0) ? amdf_pkg::PH_CKSUM
                                                               : amdf_pkg::PH_DATA;
                end
            end
            amdf_pkg::PH_DATA: begin
                if (w_in_acc) begin
                    w_we            = (r_payload_count < LP_MAX_CNT);
                    n_xor           = r_xor ^ i_rx_byte;
                    n_payload_count = w_pc_inc;
                    if (8'(w_pc_inc) >= r_frame_length) begin
                        n_phase = amdf_pkg::PH_CKSUM;
                    end
                end
            end
            amdf_pkg::PH_CKSUM: begin
                if (w_in_acc) begin
                    if (r_xor != i_rx_byte) begin
                        w_load      = 1'b1;
                        w_ld_status = amdf_pkg::ST_CKSUM;
                        w_end       = 1'b1;
                    end else if (r_frame_length == 8'd0) begin
                        w_load = 1'b1;
                        w_end  = 1'b1;
                    end else begin
                        n_phase    = amdf_pkg::PH_EMIT;
                        n_emit_cnt = '0;
                    end
                end
            end
            amdf_pkg::PH_EMIT: begin
                if (r_rd_pend) begin
                    // read data lands in the (free) output register
                    w_load    = 1'b1;
                    w_ld_idx  = 5'(r_rd_idx);
                    w_ld_data = w_rdata;
                    w_ld_has  = 1'b1;
                    w_ld_last = w_emit_last;
                    w_end     = w_emit_last;
                end else if (w_out_free) begin
                    w_re       = 1'b1;
                    n_rd_idx   = r_emit_cnt;
                    n_emit_cnt = r_emit_cnt + 1'b1;
                    n_rd_pend  = 1'b1;
                end
            end
            default: begin
                n_phase = amdf_pkg::PH_HUNT;
            end
        endcase

        if (w_end) begin
            n_phase         = amdf_pkg::PH_HUNT;
            n_skip          = 8'd0;
            n_payload_count = '0;
            n_xor           = 8'd0;
        end

        n_out_valid = w_load || (r_out_valid && !i_res_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= amdf_pkg::PH_HUNT;
            r_frame_length  <= 8'd0;
            r_frame_id      <= 8'd0;
            r_payload_count <= '0;
            r_xor           <= 8'd0;
            r_skip          <= 8'd0;
            r_emit_cnt      <= '0;
            r_rd_idx        <= '0;
            r_rd_pend       <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            r_phase         <= n_phase;
            r_frame_length  <= n_frame_length;
            r_frame_id      <= n_frame_id;
            r_payload_count <= n_payload_count;
            r_xor           <= n_xor;
            r_skip          <= n_skip;
            r_emit_cnt      <= n_emit_cnt;
            r_rd_idx        <= n_rd_idx;
            r_rd_pend       <= n_rd_pend;
            r_out_valid     <= n_out_valid;
        end
    end

    // payload of the output register: no reset needed
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_o_status <= w_ld_status;
            r_o_id     <= w_ld_id;
            r_o_len    <= w_ld_len;
            r_o_idx    <= w_ld_idx;
            r_o_data   <= w_ld_data;
            r_o_has    <= w_ld_has;
            r_o_skip   <= r_skip;
            r_o_last   <= w_ld_last;
        end
    end

    assign o_res_valid     = r_out_valid;
    assign o_status        = r_o_status;
    assign o_msg_id        = r_o_id;
    assign o_msg_len       = r_o_len;
    assign o_byte_index    = r_o_idx;
    assign o_data_byte     = r_o_data;
    assign o_has_data      = r_o_has;
    assign o_skipped_bytes = r_o_skip;
    assign o_last          = r_o_last;

    // ---- assertions ----
    `AMDF_ASSERT_NOW(a_no_rx_in_emit, r_phase == amdf_pkg::PH_EMIT, !o_rx_ready, "rx taken during emit")
    `AMDF_ASSERT_NOW(a_rd_into_free, r_rd_pend, !r_out_valid, "RAM read lands on a full output register")
    `AMDF_ASSERT_NEXT(a_rd_loads, r_rd_pend, r_out_valid, "RAM read data not loaded")
    `AMDF_ASSERT_NOW(a_cnt_in_data, r_phase == amdf_pkg::PH_DATA, 8'(r_payload_count) < r_frame_length, "payload count overran frame length")

endmodule

[tb/sv/ant_message_deframer_tb.sv]
// ----------------------------------------------------------------------------
// ant_message_deframer_tb
// Self-checking bench for the serial message deframer. Rx bytes are sent as
// requests. Each accepted byte goes through a bit-accurate frame predictor,
// and every result request is checked field by field against the oldest
// expected result. Directed tests come first, then a long result
// back-pressure stretch, and then random frame traffic under several idle
// mixes.
// ----------------------------------------------------------------------------
module ant_message_deframer_tb;

    localparam int MAX_PAYLOAD   = 32;
    localparam int DRAIN_LIMIT   = 20000;   // cycles allowed for results to drain
    localparam int SETTLE_CYCLES = 8;       // extra wait once results have drained

    typedef logic [7:0] t_bytes [$];

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] msg_id;
        logic [7:0] msg_len;
        logic [4:0] byte_index;
        logic [7:0] data_byte;
        logic       has_data;
        logic [7:0] skipped;
        logic       last;
    } t_result;

    // ------------------------------------------------------------------
    // DUT and stimulus signals
    // ------------------------------------------------------------------
    logic       i_clk      = 1'b0;
    logic       i_rst_n    = 1'b0;
    logic       i_rx_valid = 1'b0;
    logic [7:0] i_rx_byte  = 8'h00;
    logic       i_res_ready = 1'b0;
    logic       o_rx_ready;
    logic       o_res_valid;
    logic [1:0] o_status;
    logic [7:0] o_msg_id;
    logic [7:0] o_msg_len;
    logic [4:0] o_byte_index;
    logic [7:0] o_data_byte;
    logic       o_has_data;
    logic [7:0] o_skipped_bytes;
    logic       o_last;

    ant_message_deframer #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_rx_valid     (i_rx_valid),
        .o_rx_ready     (o_rx_ready),
        .i_rx_byte      (i_rx_byte),
        .o_res_valid    (o_res_valid),
        .i_res_ready    (i_res_ready),
        .o_status       (o_status),
        .o_msg_id       (o_msg_id),
        .o_msg_len      (o_msg_len),
        .o_byte_index   (o_byte_index),
        .o_data_byte    (o_data_byte),
        .o_has_data     (o_has_data),
        .o_skipped_bytes(o_skipped_bytes),
        .o_last         (o_last)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------
    t_result expected_results [$];
    int      err_count    = 0;
    int      bytes_sent   = 0;
    int      snd_idle_pct = 0;
    int      res_idle_pct = 0;
    int      hold_req     = 0;      // receiver hold-off asked by a test, in cycles

    // Frame predictor state
    amdf_pkg::t_phase rx_phase = amdf_pkg::PH_HUNT;
    logic [7:0] rx_len   = 8'h00;
    logic [7:0] rx_id    = 8'h00;
    logic [5:0] rx_count = 6'd0;
    logic [7:0] rx_xor   = 8'h00;
    logic [7:0] rx_skip  = 8'h00;
    logic [7:0] rx_store [MAX_PAYLOAD];

    // ------------------------------------------------------------------
    // Frame predictor
    // ------------------------------------------------------------------
    function automatic void push_result(logic [1:0] status, logic [7:0] id,
                                        logic [4:0] idx, logic [7:0] data,
                                        logic has, logic last);
        t_result r;
        r.status     = status;
        r.msg_id     = id;
        r.msg_len    = rx_len;
        r.byte_index = idx;
        r.data_byte  = data;
        r.has_data   = has;
        r.skipped    = rx_skip;
        r.last       = last;
        expected_results.push_back(r);
    endfunction

    // Any result, good or bad, sends the deframer back to hunting.
    function automatic void close_frame();
        rx_phase = amdf_pkg::PH_HUNT;
        rx_skip  = 8'h00;
        rx_count = 6'd0;
        rx_xor   = 8'h00;
    endfunction

    function automatic void deframe_byte(logic [7:0] b);
        case (rx_phase)
            amdf_pkg::PH_HUNT: begin
                if (b == amdf_pkg::SYNC_BYTE) begin
                    rx_xor   = b;
                    rx_count = 6'd0;
                    rx_phase = amdf_pkg::PH_LEN;
                end else if (rx_skip != 8'hFF) begin
                    rx_skip = rx_skip + 8'd1;
                end
            end
            amdf_pkg::PH_LEN: begin
                rx_len = b;
                rx_xor ^= b;
                // oversized length: reported at once, id not yet known
                if (b > MAX_PAYLOAD) begin
                    push_result(amdf_pkg::ST_LEN, 8'h00, 5'd0, 8'h00, 1'b0, 1'b1);
                    close_frame();
                end else begin
                    rx_phase = amdf_pkg::PH_ID;
                end
            end
            amdf_pkg::PH_ID: begin
                rx_id    = b;
                rx_xor  ^= b;
                rx_count = 6'd0;
                rx_phase = (rx_len == 8'h00) ? amdf_pkg::PH_CKSUM : amdf_pkg::PH_DATA;
            end
            amdf_pkg::PH_DATA: begin
                // sync bytes in here are plain payload, no resync
                if (rx_count < MAX_PAYLOAD) rx_store[rx_count[4:0]] = b;
                rx_xor  ^= b;
                rx_count = rx_count + 6'd1;
                if (8'(rx_count) >= rx_len) rx_phase = amdf_pkg::PH_CKSUM;
            end
            amdf_pkg::PH_CKSUM: begin
                if (rx_xor != b) begin
                    push_result(amdf_pkg::ST_CKSUM, rx_id, 5'd0, 8'h00, 1'b0, 1'b1);
                end else if (rx_len == 8'h00) begin
                    push_result(amdf_pkg::ST_OK, rx_id, 5'd0, 8'h00, 1'b0, 1'b1);
                end else begin
                    for (int k = 0; k < rx_len && k < MAX_PAYLOAD; k++)
                        push_result(amdf_pkg::ST_OK, rx_id, 5'(k), rx_store[k], 1'b1,
                                    (k + 1 == rx_len));
                end
                close_frame();
            end
            default: close_frame();
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Result checker: one compare per accepted result request
    // ------------------------------------------------------------------
    function automatic void check_field(string name, int unsigned exp_v,
                                        int unsigned act_v);
        if (exp_v != act_v) begin
            err_count++;
            $display("%0t: %s mismatch, expected %0d got %0d",
                     $time, name, exp_v, act_v);
        end
    endfunction

    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n && o_res_valid && i_res_ready) begin
            if (expected_results.size() == 0) begin
                err_count++;
                $display("%0t: unexpected result, expected none got status %0d id %0d",
                         $time, o_status, o_msg_id);
            end else begin
                exp_r = expected_results.pop_front();
                check_field("status",        exp_r.status,     o_status);
                check_field("msg_id",        exp_r.msg_id,     o_msg_id);
                check_field("msg_len",       exp_r.msg_len,    o_msg_len);
                check_field("byte_index",    exp_r.byte_index, o_byte_index);
                check_field("data_byte",     exp_r.data_byte,  o_data_byte);
                check_field("has_data",      exp_r.has_data,   o_has_data);
                check_field("skipped_bytes", exp_r.skipped,    o_skipped_bytes);
                check_field("last",          exp_r.last,       o_last);
            end
        end
    end

    // ------------------------------------------------------------------
    // Result ready: random stalls, plus a long hold-off counted here
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        int hold_left;
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            i_res_ready <= 1'b0;
            hold_left--;
        end else begin
            i_res_ready <= ($urandom_range(0, 99) >= res_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Rx request driver
    // ------------------------------------------------------------------
    // Valid is raised at a falling edge and held with the byte until the
    // rising edge that takes it; the predictor sees the byte at that edge.
    task automatic send_byte(input logic [7:0] b);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            i_rx_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_rx_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (!o_rx_ready);
        deframe_byte(b);
        bytes_sent++;
    endtask

    task automatic send_noise(input int n);
        logic [7:0] b;
        repeat (n) begin
            do b = 8'($urandom); while (b == amdf_pkg::SYNC_BYTE);
            send_byte(b);
        end
    endtask

    task automatic send_frame(input logic [7:0] id, input t_bytes payload,
                              input bit corrupt);
        logic [7:0] sum;
        sum = amdf_pkg::SYNC_BYTE ^ 8'(payload.size()) ^ id;
        foreach (payload[k]) sum ^= payload[k];
        if (corrupt) sum ^= 8'($urandom_range(1, 255));
        send_byte(amdf_pkg::SYNC_BYTE);
        send_byte(8'(payload.size()));
        send_byte(id);
        foreach (payload[k]) send_byte(payload[k]);
        send_byte(sum);
    endtask

    task automatic send_len_error(input logic [7:0] len);
        send_byte(amdf_pkg::SYNC_BYTE);
        send_byte(len);
    endtask

    function automatic t_bytes rand_payload(int n);
        t_bytes p;
        repeat (n) p.push_back(8'($urandom));
        return p;
    endfunction

    // Drop valid, then wait for every expected result (bounded) and settle.
    task automatic wait_drained();
        int n;
        @(negedge i_clk);
        i_rx_valid <= 1'b0;
        n = 0;
        while (expected_results.size() != 0 && n < DRAIN_LIMIT) begin
            @(posedge i_clk);
            n++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Zero-length frames: one empty good result, and a bad checksum on one.
    task automatic test_empty_frame();
        t_bytes none;
        send_frame(8'h00, none, 1'b0);
        send_frame(8'hFF, none, 1'b1);
    endtask

    // Field extremes, skipped bytes reported, sync byte carried as payload.
    task automatic test_extremes();
        t_bytes p;
        send_noise(3);
        p = '{8'h00};
        send_frame(8'h5A, p, 1'b0);
        p = '{8'hFF, amdf_pkg::SYNC_BYTE, 8'h00};
        send_frame(8'hFF, p, 1'b0);
    endtask

    // Oversized lengths, including the sync value itself as a length.
    task automatic test_length_error();
        send_noise(2);
        send_len_error(8'(MAX_PAYLOAD + 1));
        send_len_error(8'hFF);
        send_len_error(amdf_pkg::SYNC_BYTE);
    endtask

    task automatic test_checksum_error();
        send_frame(8'h81, rand_payload(3), 1'b1);
        send_frame(amdf_pkg::SYNC_BYTE, rand_payload(1), 1'b0);
    endtask

    // 256 junk bytes: count reaches 255 and must stick there.
    task automatic test_skip_saturation();
        t_bytes none;
        send_noise(256);
        send_frame(8'h3C, none, 1'b0);
    endtask

    // Receiver held off for a long stretch while frames keep coming, so the
    // output stalls and rx requests back up.
    task automatic test_backpressure();
        hold_req = 400;
        send_frame(8'($urandom), rand_payload(MAX_PAYLOAD), 1'b0);
        send_frame(8'($urandom), rand_payload(4), 1'b0);
    endtask

    // Mostly well-formed frames with random content, some broken frames and
    // loose noise (which may itself hold sync bytes).
    task automatic random_traffic(input int n_bytes);
        int start;
        int kind;
        int len;
        start = bytes_sent;
        while (bytes_sent - start < n_bytes) begin
            kind = $urandom_range(0, 99);
            len  = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 6)
                                               : $urandom_range(7, MAX_PAYLOAD);
            if ($urandom_range(0, 3) == 0) send_noise($urandom_range(1, 3));
            if (kind < 68)
                send_frame(8'($urandom), rand_payload(len), 1'b0);
            else if (kind < 80)
                send_frame(8'($urandom), rand_payload(len), 1'b1);
            else if (kind < 88)
                send_len_error(8'($urandom_range(MAX_PAYLOAD + 1, 255)));
            else
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
        end
    endtask

    task automatic test_random();
        snd_idle_pct = 18;
        res_idle_pct = 61;
        random_traffic(8);
        wait_drained();
        snd_idle_pct = 61;
        res_idle_pct = 18;
        random_traffic(8);
        wait_drained();
        snd_idle_pct = 0;
        res_idle_pct = 0;
        random_traffic(8);
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        snd_idle_pct = 18;
        res_idle_pct = 61;
        test_empty_frame();
        wait_drained();
        test_extremes();
        wait_drained();
        test_length_error();
        wait_drained();
        test_checksum_error();
        wait_drained();
        test_skip_saturation();
        wait_drained();
        test_backpressure();
        wait_drained();
        test_random();
        wait_drained();

        if (expected_results.size() != 0) begin
            err_count++;
            $display("%0t: %0d expected results never arrived",
                     $time, expected_results.size());
        end
        if (err_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run
    initial begin
        #5000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
